/* rtl/core/seven_segment_scanner_with_debounce_defines.svh */
`ifndef SEVEN_SEGMENT_SCANNER_WITH_DEBOUNCE_DEFINES_SVH
`define SEVEN_SEGMENT_SCANNER_WITH_DEBOUNCE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define SSS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define SSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/sss_pkg.sv */
`timescale 1ns / 1ps

package sss_pkg;

  localparam logic [2:0] ACT_SHOW_NUMBER = 3'd0;
  localparam logic [2:0] ACT_SET_LEDS    = 3'd1;
  localparam logic [2:0] ACT_SET_STATUS  = 3'd2;
  localparam logic [2:0] ACT_PHASE_ON    = 3'd3;
  localparam logic [2:0] ACT_PHASE_OFF   = 3'd4;
  localparam logic [2:0] ACT_PERIOD_END  = 3'd5;

  localparam logic [1:0] BASE_DEC = 2'd0;
  localparam logic [1:0] BASE_OCT = 2'd1;
  localparam logic [1:0] BASE_HEX = 2'd2;

  localparam logic [2:0] PH_LEDS   = 3'd4;
  localparam logic [2:0] PH_STATUS = 3'd5;
  localparam logic [2:0] PH_SWITCH = 3'd6;

  localparam logic       CFG_MODE_RELOAD = 1'b0;
  localparam logic       CFG_GO_RELOAD   = 1'b1;
  localparam logic [3:0] RELOAD_RESET    = 4'd10;

  localparam logic [7:0] X_PATTERN = 8'h97;

  function automatic logic [7:0] seg_lookup(input logic [3:0] digit);
    logic [7:0] pat;
    unique case (digit)
      4'h0: pat = 8'hF5;
      4'h1: pat = 8'h05;
      4'h2: pat = 8'hE3;
      4'h3: pat = 8'h67;
      4'h4: pat = 8'h17;
      4'h5: pat = 8'h76;
      4'h6: pat = 8'hF6;
      4'h7: pat = 8'h45;
      4'h8: pat = 8'hF7;
      4'h9: pat = 8'h77;
      4'hA: pat = 8'hD7;
      4'hB: pat = 8'hB6;
      4'hC: pat = 8'hF0;
      4'hD: pat = 8'hA7;
      4'hE: pat = 8'hF2;
      default: pat = 8'hD2;
    endcase
    return pat;
  endfunction

endpackage

/* rtl/core/seven_segment_scanner_with_debounce.sv */
`timescale 1ns / 1ps
// A word accepted at one clock edge has its result word valid after that edge.
// Throughput: one word per cycle unless out_ready stalls; one pass through the state registers.
// The result register holds the panel state and frees whenever its word is taken.
// Reset (synchronous, rst_n low): scan at first digit, patterns, LEDs, counters and flags zero,
// bus driven, both debounce reloads 10, no result word pending.
`include "seven_segment_scanner_with_debounce_defines.svh"

module seven_segment_scanner_with_debounce (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [3:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_action,
  input  logic [7:0] in_number_value,
  input  logic [1:0] in_number_base,
  input  logic [7:0] in_prefix_pattern,
  input  logic [7:0] in_led_value,
  input  logic [1:0] in_status_index,
  input  logic       in_status_on,
  input  logic [7:0] in_switch_pins,
  input  logic       in_mode_pin,
  input  logic       in_go_pin,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_segment_bus,
  output logic       out_bus_drive,
  output logic [5:0] out_select_onehot,
  output logic [7:0] out_switches_seen,
  output logic       out_mode_pressed,
  output logic       out_go_pressed,
  output logic [2:0] out_scan_step
);

  logic [3:0] mode_reload_r, go_reload_r;
  logic       out_valid_r;
  logic [2:0] phase_r, phase_nxt;
  logic [7:0] digit_r [4];
  logic [7:0] digit_nxt [4];
  logic [7:0] led_r, led_nxt;
  logic [3:0] status_r, status_nxt;
  logic [7:0] switch_r, switch_nxt;
  logic [3:0] mode_cnt_r, mode_cnt_nxt, go_cnt_r, go_cnt_nxt;
  logic       mode_flag_r, mode_flag_nxt, go_flag_r, go_flag_nxt;
  logic [7:0] seg_r, seg_nxt;
  logic       drive_r, drive_nxt;
  logic [5:0] sel_r, sel_nxt;
  logic       accept;

  // decimal split
  logic [1:0]  hundreds;
  logic [6:0]  rem100;
  logic [14:0] tens_prod;
  logic [3:0]  tens, ones;
  logic [7:0]  tens_x10;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    priority if (in_number_value >= 8'd200) begin
      hundreds = 2'd2;
      rem100   = 7'(in_number_value - 8'd200);
    end else if (in_number_value >= 8'd100) begin
      hundreds = 2'd1;
      rem100   = 7'(in_number_value - 8'd100);
    end else begin
      hundreds = 2'd0;
      rem100   = in_number_value[6:0];
    end
    tens_prod = 15'(rem100) * 15'd205;
    tens      = tens_prod[14:11];
    tens_x10  = {1'b0, tens, 3'b000} + {3'b000, tens, 1'b0};
    ones      = 4'(8'(rem100) - tens_x10);
  end

  always_comb begin
    phase_nxt     = phase_r;
    digit_nxt     = digit_r;
    led_nxt       = led_r;
    status_nxt    = status_r;
    switch_nxt    = switch_r;
    mode_cnt_nxt  = mode_cnt_r;
    go_cnt_nxt    = go_cnt_r;
    mode_flag_nxt = mode_flag_r;
    go_flag_nxt   = go_flag_r;
    seg_nxt       = seg_r;
    drive_nxt     = drive_r;
    sel_nxt       = sel_r;
    unique case (in_action)
      sss_pkg::ACT_SHOW_NUMBER: begin
        unique case (in_number_base)
          sss_pkg::BASE_DEC: begin
            digit_nxt[0] = in_prefix_pattern;
            digit_nxt[3] = sss_pkg::seg_lookup(ones);
            digit_nxt[2] = (in_number_value >= 8'd10) ? sss_pkg::seg_lookup(tens) : 8'h00;
            digit_nxt[1] = (hundreds != 2'd0) ? sss_pkg::seg_lookup({2'b00, hundreds}) : 8'h00;
          end
          sss_pkg::BASE_OCT: begin
            digit_nxt[0] = sss_pkg::seg_lookup(4'h0);
            digit_nxt[1] = sss_pkg::seg_lookup({2'b00, in_number_value[7:6]});
            digit_nxt[2] = sss_pkg::seg_lookup({1'b0, in_number_value[5:3]});
            digit_nxt[3] = sss_pkg::seg_lookup({1'b0, in_number_value[2:0]});
          end
          sss_pkg::BASE_HEX: begin
            digit_nxt[0] = sss_pkg::seg_lookup(4'h0);
            digit_nxt[1] = sss_pkg::X_PATTERN;
            digit_nxt[2] = sss_pkg::seg_lookup(in_number_value[7:4]);
            digit_nxt[3] = sss_pkg::seg_lookup(in_number_value[3:0]);
          end
          default: ;
        endcase
      end
      sss_pkg::ACT_SET_LEDS: led_nxt = in_led_value;
      sss_pkg::ACT_SET_STATUS: status_nxt[in_status_index] = in_status_on;
      sss_pkg::ACT_PHASE_ON: begin
        if (phase_r < sss_pkg::PH_LEDS) begin
          seg_nxt = digit_r[phase_r[1:0]];
          sel_nxt = sel_r | (6'd1 << phase_r[1:0]);
        end else if (phase_r == sss_pkg::PH_LEDS) begin
          seg_nxt = led_r;
          sel_nxt = sel_r | 6'h10;
        end else if (phase_r == sss_pkg::PH_STATUS) begin
          seg_nxt = {status_r, 4'h0};
          sel_nxt = sel_r | 6'h20;
        end else if (phase_r == sss_pkg::PH_SWITCH) begin
          drive_nxt = 1'b0;
          seg_nxt   = 8'hFF;
        end
      end
      sss_pkg::ACT_PHASE_OFF: begin
        if (phase_r <= sss_pkg::PH_STATUS) begin
          seg_nxt = 8'h00;
          sel_nxt = 6'h00;
        end else if (phase_r == sss_pkg::PH_SWITCH) begin
          switch_nxt = ~in_switch_pins;
        end
      end
      sss_pkg::ACT_PERIOD_END: begin
        if (phase_r < sss_pkg::PH_SWITCH) begin
          phase_nxt = phase_r + 3'd1;
        end else begin
          seg_nxt   = 8'h00;
          drive_nxt = 1'b1;
          phase_nxt = 3'd0;
        end
        if (mode_cnt_r != 4'd0) begin
          mode_cnt_nxt = mode_cnt_r - 4'd1;
        end else if (!in_mode_pin != mode_flag_r) begin
          mode_flag_nxt = !in_mode_pin;
          mode_cnt_nxt  = mode_reload_r;
        end
        if (go_cnt_r != 4'd0) begin
          go_cnt_nxt = go_cnt_r - 4'd1;
        end else if (!in_go_pin != go_flag_r) begin
          go_flag_nxt = !in_go_pin;
          go_cnt_nxt  = go_reload_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_reload_r <= sss_pkg::RELOAD_RESET;
      go_reload_r   <= sss_pkg::RELOAD_RESET;
    end else if (cfg_we) begin
      if (cfg_index == sss_pkg::CFG_MODE_RELOAD) begin
        mode_reload_r <= cfg_wdata;
      end else begin
        go_reload_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 3'd0;
      digit_r     <= '{default: 8'h00};
      led_r       <= 8'h00;
      status_r    <= 4'h0;
      switch_r    <= 8'h00;
      mode_cnt_r  <= 4'd0;
      go_cnt_r    <= 4'd0;
      mode_flag_r <= 1'b0;
      go_flag_r   <= 1'b0;
      seg_r       <= 8'h00;
      drive_r     <= 1'b1;
      sel_r       <= 6'h00;
    end else begin
      if (accept) begin
        out_valid_r <= 1'b1;
        phase_r     <= phase_nxt;
        digit_r     <= digit_nxt;
        led_r       <= led_nxt;
        status_r    <= status_nxt;
        switch_r    <= switch_nxt;
        mode_cnt_r  <= mode_cnt_nxt;
        go_cnt_r    <= go_cnt_nxt;
        mode_flag_r <= mode_flag_nxt;
        go_flag_r   <= go_flag_nxt;
        seg_r       <= seg_nxt;
        drive_r     <= drive_nxt;
        sel_r       <= sel_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_segment_bus   = seg_r;
  assign out_bus_drive     = drive_r;
  assign out_select_onehot = sel_r;
  assign out_switches_seen = switch_r;
  assign out_mode_pressed  = mode_flag_r;
  assign out_go_pressed    = go_flag_r;
  assign out_scan_step     = phase_r;

  `SSS_ASSERT_NOW(a_undriven_only_in_switch_phase, !drive_r, (phase_r == sss_pkg::PH_SWITCH) && (seg_r == 8'hFF), "bus released outside switch phase")
  `SSS_ASSERT_NEXT(a_wrap_restores_bus, accept && (in_action == sss_pkg::ACT_PERIOD_END) && (phase_r == sss_pkg::PH_SWITCH), (phase_r == 3'd0) && drive_r && (seg_r == 8'h00), "scan wrap did not restore bus")
  `SSS_ASSERT_NOW(a_no_accept_while_blocked, out_valid_r && !out_ready, !accept, "word accepted while result pending")

endmodule

/* tb/sv/seven_segment_scanner_with_debounce_test.sv */
`timescale 1ns / 1ps

import sss_pkg::*;

localparam logic [1:0] BASE_NONE    = 2'd3;
localparam logic [2:0] ACT_SPARE_LO = 3'd6;
localparam logic [2:0] ACT_SPARE_HI = 3'd7;

typedef struct packed {
  logic [2:0] action;
  logic [7:0] number;
  logic [1:0] base;
  logic [7:0] prefix;
  logic [7:0] leds;
  logic [1:0] status_idx;
  logic       status_on;
  logic [7:0] pins;
  logic       mode_pin;
  logic       go_pin;
} panel_cmd_t;

typedef struct packed {
  logic [7:0] seg;
  logic       drive;
  logic [5:0] sel;
  logic [7:0] switches;
  logic       mode;
  logic       go;
  logic [2:0] step;
} panel_view_t;

class panel_scoreboard;
  bit [7:0] glyphs[16];
  bit [3:0] mode_reload;
  bit [3:0] go_reload;
  bit [2:0] phase;
  bit [7:0] digits[4];
  bit [7:0] leds;
  bit [3:0] status;
  bit [7:0] sw_latch;
  bit [3:0] mode_cnt;
  bit [3:0] go_cnt;
  bit       mode_flag;
  bit       go_flag;
  bit [7:0] seg;
  bit       drive;
  bit [5:0] sel;
  panel_view_t expected_views[$];
  int mismatches;

  function new();
    glyphs = '{8'hF5, 8'h05, 8'hE3, 8'h67, 8'h17, 8'h76, 8'hF6, 8'h45,
               8'hF7, 8'h77, 8'hD7, 8'hB6, 8'hF0, 8'hA7, 8'hF2, 8'hD2};
    mode_reload = RELOAD_RESET;
    go_reload = RELOAD_RESET;
    phase = 3'd0;
    digits = '{8'h00, 8'h00, 8'h00, 8'h00};
    leds = 8'h00;
    status = 4'h0;
    sw_latch = 8'h00;
    mode_cnt = 4'd0;
    go_cnt = 4'd0;
    mode_flag = 1'b0;
    go_flag = 1'b0;
    seg = 8'h00;
    drive = 1'b1;
    sel = 6'd0;
    mismatches = 0;
  endfunction

  function void set_reload(logic idx, bit [3:0] value);
    if (idx == CFG_MODE_RELOAD) mode_reload = value;
    else go_reload = value;
  endfunction

  function void show(bit [7:0] val, bit [1:0] base, bit [7:0] prefix);
    int v;
    int pos;
    if (base == BASE_DEC) begin
      v = int'(val);
      pos = 3;
      digits[0] = prefix;
      digits[1] = 8'h00;
      digits[2] = 8'h00;
      digits[3] = 8'h00;
      do begin
        digits[pos] = glyphs[v % 10];
        v = v / 10;
        pos--;
      end while (v != 0);
    end else if (base == BASE_OCT) begin
      digits[3] = glyphs[val[2:0]];
      digits[2] = glyphs[val[5:3]];
      digits[1] = glyphs[val[7:6]];
      digits[0] = glyphs[0];
    end else if (base == BASE_HEX) begin
      digits[3] = glyphs[val[3:0]];
      digits[2] = glyphs[val[7:4]];
      digits[1] = X_PATTERN;
      digits[0] = glyphs[0];
    end
  endfunction

  function void debounce(inout bit [3:0] cnt, inout bit flag, input bit pin,
                         input bit [3:0] reload);
    if (cnt != 4'd0) begin
      cnt = cnt - 4'd1;
    end else if (!pin != flag) begin
      flag = !pin;
      cnt = reload;
    end
  endfunction

  function void note_word(panel_cmd_t c);
    panel_view_t v;
    case (c.action)
      ACT_SHOW_NUMBER: show(c.number, c.base, c.prefix);
      ACT_SET_LEDS: leds = c.leds;
      ACT_SET_STATUS: status[c.status_idx] = c.status_on;
      ACT_PHASE_ON: begin
        if (phase < PH_LEDS) begin
          seg = digits[phase[1:0]];
          sel[phase[1:0]] = 1'b1;
        end else if (phase == PH_LEDS) begin
          seg = leds;
          sel[4] = 1'b1;
        end else if (phase == PH_STATUS) begin
          seg = {status, 4'h0};
          sel[5] = 1'b1;
        end else if (phase == PH_SWITCH) begin
          drive = 1'b0;
          seg = 8'hFF;
        end
      end
      ACT_PHASE_OFF: begin
        if (phase <= PH_STATUS) begin
          seg = 8'h00;
          sel = 6'd0;
        end else if (phase == PH_SWITCH) begin
          sw_latch = ~c.pins;
        end
      end
      ACT_PERIOD_END: begin
        if (phase < PH_SWITCH) begin
          phase = phase + 3'd1;
        end else begin
          seg = 8'h00;
          drive = 1'b1;
          phase = 3'd0;
        end
        debounce(mode_cnt, mode_flag, c.mode_pin, mode_reload);
        debounce(go_cnt, go_flag, c.go_pin, go_reload);
      end
      default: ;
    endcase
    v.seg = seg;
    v.drive = drive;
    v.sel = sel;
    v.switches = sw_latch;
    v.mode = mode_flag;
    v.go = go_flag;
    v.step = phase;
    expected_views.push_back(v);
  endfunction

  function void check_view(panel_view_t got);
    panel_view_t exp;
    if (expected_views.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected word: seg %h drive %b sel %h sw %h mode %b go %b step %0d",
                 got.seg, got.drive, got.sel, got.switches, got.mode, got.go, got.step);
      return;
    end
    exp = expected_views.pop_front();
    if (got.seg !== exp.seg || got.drive !== exp.drive || got.sel !== exp.sel ||
        got.switches !== exp.switches || got.mode !== exp.mode || got.go !== exp.go ||
        got.step !== exp.step) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch exp: seg %h drive %b sel %h sw %h mode %b go %b step %0d",
                 exp.seg, exp.drive, exp.sel, exp.switches, exp.mode, exp.go, exp.step);
        $display("         got: seg %h drive %b sel %h sw %h mode %b go %b step %0d",
                 got.seg, got.drive, got.sel, got.switches, got.mode, got.go, got.step);
      end
    end
  endfunction
endclass

module seven_segment_scanner_with_debounce_test;
  localparam int CYCLE_LIMIT = 400000;
  localparam int WORDS_PER_SETTING = 180;
  localparam int HOLD_CYCLES = 300;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_index;
  logic [3:0] cfg_wdata;
  logic       in_valid;
  logic       in_ready;
  logic [2:0] in_action;
  logic [7:0] in_number_value;
  logic [1:0] in_number_base;
  logic [7:0] in_prefix_pattern;
  logic [7:0] in_led_value;
  logic [1:0] in_status_index;
  logic       in_status_on;
  logic [7:0] in_switch_pins;
  logic       in_mode_pin;
  logic       in_go_pin;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_segment_bus;
  logic       out_bus_drive;
  logic [5:0] out_select_onehot;
  logic [7:0] out_switches_seen;
  logic       out_mode_pressed;
  logic       out_go_pressed;
  logic [2:0] out_scan_step;

  panel_scoreboard sb = new();
  int  cycles = 0;
  int  words_sent = 0;
  int  stall_left = 0;
  int  hold_ticket = 0;
  int  hold_seen = 0;
  bit  calm = 1'b0;
  bit  mode_level = 1'b1;
  bit  go_level = 1'b1;

  seven_segment_scanner_with_debounce uut (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    panel_view_t got;
    got.seg = out_segment_bus;
    got.drive = out_bus_drive;
    got.sel = out_select_onehot;
    got.switches = out_switches_seen;
    got.mode = out_mode_pressed;
    got.go = out_go_pressed;
    got.step = out_scan_step;
    if (rst_n && out_valid && out_ready) sb.check_view(got);
    if (hold_ticket != hold_seen) begin
      hold_seen = hold_ticket;
      stall_left = HOLD_CYCLES;
    end else if (stall_left == 0 && !calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 19);
    end
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic panel_cmd_t make_cmd(logic [2:0] action);
    panel_cmd_t c;
    c.action = action;
    case ($urandom_range(0, 5))
      0: c.number = 8'h00;
      1: c.number = 8'hFF;
      default: c.number = 8'($urandom_range(0, 255));
    endcase
    c.base = 2'($urandom_range(BASE_DEC, BASE_NONE));
    c.prefix = 8'($urandom_range(0, 255));
    c.leds = 8'($urandom_range(0, 255));
    c.status_idx = 2'($urandom_range(0, 3));
    c.status_on = 1'($urandom_range(0, 1));
    c.pins = 8'($urandom_range(0, 255));
    if (action == ACT_PERIOD_END) begin
      if ($urandom_range(0, 4) == 0) mode_level = ~mode_level;
      if ($urandom_range(0, 4) == 0) go_level = ~go_level;
    end
    c.mode_pin = mode_level;
    c.go_pin = go_level;
    return c;
  endfunction

  task automatic send_word(panel_cmd_t c);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= c.action;
    in_number_value <= c.number;
    in_number_base <= c.base;
    in_prefix_pattern <= c.prefix;
    in_led_value <= c.leds;
    in_status_index <= c.status_idx;
    in_status_on <= c.status_on;
    in_switch_pins <= c.pins;
    in_mode_pin <= c.mode_pin;
    in_go_pin <= c.go_pin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(c);
    words_sent++;
  endtask

  task automatic drain_block();
    in_valid <= 1'b0;
    while (sb.expected_views.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_reloads(bit [3:0] mode_val, bit [3:0] go_val);
    drain_block();
    cfg_we <= 1'b1;
    cfg_index <= CFG_MODE_RELOAD;
    cfg_wdata <= mode_val;
    @(posedge clk);
    cfg_index <= CFG_GO_RELOAD;
    cfg_wdata <= go_val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reload(CFG_MODE_RELOAD, mode_val);
    sb.set_reload(CFG_GO_RELOAD, go_val);
    @(posedge clk);
  endtask

  task automatic send_data_word();
    case ($urandom_range(0, 2))
      0: send_word(make_cmd(ACT_SHOW_NUMBER));
      1: send_word(make_cmd(ACT_SET_LEDS));
      default: send_word(make_cmd(ACT_SET_STATUS));
    endcase
  endtask

  task automatic run_scan_cycle();
    for (int p = 0; p < 7; p++) begin
      if ($urandom_range(0, 2) == 0) send_data_word();
      send_word(make_cmd(ACT_PHASE_ON));
      if ($urandom_range(0, 5) == 0) send_word(make_cmd(ACT_PHASE_ON));
      if ($urandom_range(0, 9) != 0) send_word(make_cmd(ACT_PHASE_OFF));
      send_word(make_cmd(ACT_PERIOD_END));
    end
  endtask

  task automatic run_directed();
    panel_cmd_t c;
    c = make_cmd(ACT_SHOW_NUMBER);
    c.base = BASE_DEC; c.number = 8'd0; c.prefix = 8'hFF;
    send_word(c);
    c.number = 8'd255; c.prefix = 8'h00;
    send_word(c);
    c.number = 8'd7;
    send_word(c);
    c.number = 8'd42;
    send_word(c);
    c.base = BASE_OCT; c.number = 8'hFF;
    send_word(c);
    c.base = BASE_HEX; c.number = 8'hA5;
    send_word(c);
    c.base = BASE_NONE; c.number = 8'h12;
    send_word(c);
    c = make_cmd(ACT_SET_LEDS);
    c.leds = 8'hFF;
    send_word(c);
    c = make_cmd(ACT_SET_STATUS);
    c.status_idx = 2'd3; c.status_on = 1'b1;
    send_word(c);
    c.status_idx = 2'd0;
    send_word(c);
    c.status_idx = 2'd3; c.status_on = 1'b0;
    send_word(c);
    send_word(make_cmd(ACT_SPARE_LO));
    send_word(make_cmd(ACT_SPARE_HI));
    send_word(make_cmd(ACT_PHASE_ON));
    send_word(make_cmd(ACT_PHASE_ON));
    send_word(make_cmd(ACT_PHASE_OFF));
    mode_level = 1'b0;
    go_level = 1'b0;
    repeat (6) begin
      c = make_cmd(ACT_PERIOD_END);
      c.mode_pin = 1'b0; c.go_pin = 1'b0;
      send_word(c);
    end
    send_word(make_cmd(ACT_PHASE_ON));
    c = make_cmd(ACT_PHASE_OFF);
    c.pins = 8'h5A;
    send_word(c);
    send_word(make_cmd(ACT_PERIOD_END));
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_MODE_RELOAD;
    cfg_wdata = 4'd0;
    in_valid = 1'b0;
    in_action = ACT_SHOW_NUMBER;
    in_number_value = 8'h00;
    in_number_base = BASE_DEC;
    in_prefix_pattern = 8'h00;
    in_led_value = 8'h00;
    in_status_index = 2'd0;
    in_status_on = 1'b0;
    in_switch_pins = 8'h00;
    in_mode_pin = 1'b1;
    in_go_pin = 1'b1;
    out_ready = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    for (int s = 0; s < 5; s++) begin
      case (s)
        1: set_reloads(4'd0, 4'd15);
        2: set_reloads(4'd15, 4'd0);
        3: set_reloads(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
        4: begin
          set_reloads(4'($urandom_range(1, 5)), 4'($urandom_range(1, 5)));
          calm <= 1'b1;
        end
        default: ;
      endcase
      while (words_sent < (s + 1) * WORDS_PER_SETTING) begin
        if (s == 1 && hold_ticket == 0 && words_sent > WORDS_PER_SETTING + 40)
          hold_ticket <= hold_ticket + 1;
        if (s == 2 && $urandom_range(0, 15) == 0) drain_block();
        if ($urandom_range(0, 5) == 0) send_word(make_cmd(3'($urandom_range(ACT_SHOW_NUMBER,
                                                                             ACT_SPARE_HI))));
        else run_scan_cycle();
      end
    end

    drain_block();
    repeat (4) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_views.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
